[design/assert_macros.svh]
// Assertion macros shared by the Playfair cipher RTL.
// Stand-alone header; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When ante holds at an edge, cons holds at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// When ante holds at an edge, cons holds at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/pdc_pkg.sv]
// Types, constants and helper functions of the Playfair cipher block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pdc_pkg;

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_pos;

    // Five rows of five 5-bit cells; cell c of a row sits at bits 5c+4..5c.
    typedef logic [4:0][24:0] t_square;

    // One unit of work handed from the front to the back.
    // two: doubled letter at message end; emits (a, X) then (b, X).
    typedef struct packed {
        t_letter a;
        t_letter b;
        logic    dec;
        logic    last;
        logic    two;
    } t_job;

    typedef struct packed {
        t_pos row;
        t_pos col;
    } t_loc;

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;

    localparam logic [2:0] CFG_ROW_LAST = 3'd4;

    localparam t_square SQUARE_RESET = {
        25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
    };

    function automatic t_pos next5(input t_pos p);
        t_pos q;
        case (p)
            3'd0:    q = 3'd1;
            3'd1:    q = 3'd2;
            3'd2:    q = 3'd3;
            3'd3:    q = 3'd4;
            default: q = 3'd0;
        endcase
        return q;
    endfunction

    function automatic t_pos prev5(input t_pos p);
        t_pos q;
        case (p)
            3'd1:    q = 3'd0;
            3'd2:    q = 3'd1;
            3'd3:    q = 3'd2;
            3'd4:    q = 3'd3;
            default: q = 3'd4;
        endcase
        return q;
    endfunction

endpackage

[design/pdc_front.sv]
// Front end of the Playfair cipher: pairs incoming letters and classifies pairs.
// Depends on pdc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_mode,
    input  pdc_pkg::t_letter i_letter,
    input  logic            i_last,
    input  logic            i_full,
    output logic            o_push,
    output pdc_pkg::t_job   o_job
);
    import pdc_pkg::*;

    logic    r_pend_valid;
    t_letter r_pend;
    logic    n_pend_valid;
    t_letter n_pend;
    t_letter letter_fix;
    logic    accept;

    assign o_ready    = !i_full;
    assign accept     = i_valid && o_ready;
    assign letter_fix = (i_letter == LETTER_J) ? LETTER_I : i_letter;

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_push       = 1'b0;
        o_job        = '0;
        if (accept) begin
            if (!r_pend_valid) begin
                if (i_last) begin
                    // Lone final letter is padded with X.
                    o_push = 1'b1;
                    o_job  = '{a: letter_fix, b: LETTER_X, dec: i_mode, last: 1'b1,
                               two: 1'b0};
                end else begin
                    n_pend_valid = 1'b1;
                    n_pend       = letter_fix;
                end
            end else if (!i_mode && (r_pend == letter_fix)) begin
                // Doubled letter in encrypt mode: X goes between the two.
                o_push = 1'b1;
                if (i_last) begin
                    o_job = '{a: r_pend, b: letter_fix, dec: 1'b0, last: 1'b1,
                              two: 1'b1};
                    n_pend_valid = 1'b0;
                    n_pend       = '0;
                end else begin
                    o_job = '{a: r_pend, b: LETTER_X, dec: 1'b0, last: 1'b0,
                              two: 1'b0};
                    n_pend = letter_fix;
                end
            end else begin
                o_push = 1'b1;
                o_job  = '{a: r_pend, b: letter_fix, dec: i_mode, last: i_last,
                           two: 1'b0};
                n_pend_valid = 1'b0;
                n_pend       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend       <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend       <= n_pend;
        end
    end

    `ASSERT_NEXT(a_pend_set, i_clk, i_rst_n, accept && !r_pend_valid && !i_last, r_pend_valid)
    `ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, o_push, !i_full)

endmodule

[design/pdc_queue.sv]
// Short job queue between the front and the back of the Playfair cipher.
// Depends on pdc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pdc_pkg::t_job i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pdc_pkg::t_job o_rdata
);
    import pdc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_FULL)
    `ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

[design/pdc_back.sv]
// Back end of the Playfair cipher: key square registers, pair lookup and output register.
// Depends on pdc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [24:0]      i_cfg_data,
    input  logic             i_job_valid,
    input  pdc_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output pdc_pkg::t_letter o_first,
    output pdc_pkg::t_letter o_second,
    output logic             o_first_keep,
    output logic             o_second_keep,
    output logic             o_last
);
    import pdc_pkg::*;

    t_square r_square;
    logic    r_half;
    logic    r_valid;
    t_letter r_first;
    t_letter r_second;
    logic    r_fkeep;
    logic    r_skeep;
    logic    r_last;

    logic    advance;
    t_letter pa;
    t_letter pb;
    logic    dec;
    logic    last;
    t_loc    l1;
    t_loc    l2;
    t_letter fa;
    t_letter fb;

    // Last match in row-major order wins; a missing letter sits at row 0, column 0.
    function automatic t_loc locate(input t_square sq, input t_letter l);
        t_loc loc;
        loc = '0;
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (sq[r][5*c +: 5] == l) begin
                    loc.row = 3'(r);
                    loc.col = 3'(c);
                end
            end
        end
        return loc;
    endfunction

    function automatic t_letter cell_at(input t_square sq, input t_pos row, input t_pos col);
        return sq[row][5*col +: 5];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_valid || i_ready;
    assign o_pop       = advance && i_job_valid && (!i_job.two || r_half);

    always_comb begin
        pa   = r_half ? i_job.b : i_job.a;
        pb   = i_job.two ? LETTER_X : i_job.b;
        dec  = i_job.dec && !i_job.two;
        last = i_job.two ? r_half : i_job.last;
        l1   = locate(r_square, pa);
        l2   = locate(r_square, pb);
        if (l1.row == l2.row) begin
            // Same row, and also the same cell: shift along the row.
            fa = cell_at(r_square, l1.row, dec ? prev5(l1.col) : next5(l1.col));
            fb = cell_at(r_square, l2.row, dec ? prev5(l2.col) : next5(l2.col));
        end else if (l1.col == l2.col) begin
            fa = cell_at(r_square, dec ? prev5(l1.row) : next5(l1.row), l1.col);
            fb = cell_at(r_square, dec ? prev5(l2.row) : next5(l2.row), l2.col);
        end else begin
            fa = cell_at(r_square, l1.row, l2.col);
            fb = cell_at(r_square, l2.row, l1.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= SQUARE_RESET;
            r_half   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index <= CFG_ROW_LAST)) begin
                r_square[i_cfg_index] <= i_cfg_data;
            end
            if (advance) begin
                r_valid <= i_job_valid;
                if (i_job_valid && i_job.two) begin
                    r_half <= !r_half;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_job_valid) begin
            r_first  <= fa;
            r_second <= fb;
            r_fkeep  <= !(dec && (fa == LETTER_X));
            r_skeep  <= !(dec && (fb == LETTER_X));
            r_last   <= last;
        end
    end

    assign o_valid       = r_valid;
    assign o_first       = r_first;
    assign o_second      = r_second;
    assign o_first_keep  = r_fkeep;
    assign o_second_keep = r_skeep;
    assign o_last        = r_last;

    `ASSERT_IMPLIES(a_half_job, i_clk, i_rst_n, r_half, i_job_valid && i_job.two)

endmodule

[design/playfair_digraph_cipher.sv]
// Playfair digraph cipher: one letter per item in, one transformed pair per result out.
// A completed pair's job goes through the job queue and then the output register.
// Throughput: one item per cycle while the job queue is not full; the queue and output
// register set that figure, and a doubled final letter gives its two results in separate passes.
// Reset (synchronous, active low) clears the pending letter, the queue and the output, and
// loads the plain key square ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ.
`timescale 1ns / 1ps

module playfair_digraph_cipher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Letter stream in.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [4:0] letter, [7:5] zero
    input  logic [0:0]  i_s_tuser,   // [0] mode: 0 encrypt, 1 decrypt
    input  logic        i_s_tlast,   // message_end
    // Pair stream out.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [4:0] first_letter, [9:5] second_letter,
                                     // [10] first_keep, [11] second_keep, [15:12] zero
    output logic        o_m_tlast,   // run_end
    // Key square register writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [24:0] i_cfg_data
);
    import pdc_pkg::*;

    // The front pairs letters, handles the doubled and lone final letter cases,
    // and pushes one job per pair into the queue. It only stalls when the queue
    // is full, so it keeps taking items while a result waits at the output.
    logic    push;
    t_job    push_job;
    logic    q_full;
    logic    q_valid;
    t_job    q_job;
    logic    pop;
    t_letter first;
    t_letter second;

    pdc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_mode   (i_s_tuser[0]),
        .i_letter (i_s_tdata[4:0]),
        .i_last   (i_s_tlast),
        .i_full   (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    pdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rdata (q_job)
    );

    // The back locates both letters in the square, applies the row, column or
    // rectangle rule and registers the result. A doubled-letter job at message
    // end is worked off in two passes before it leaves the queue.
    pdc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_first       (first),
        .o_second      (second),
        .o_first_keep  (o_m_tdata[10]),
        .o_second_keep (o_m_tdata[11]),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata[4:0]   = first;
    assign o_m_tdata[9:5]   = second;
    assign o_m_tdata[15:12] = 4'd0;

endmodule

[tb/playfair_digraph_cipher_checker.sv]
// Scoreboard for the Playfair digraph cipher: it watches the letter, pair and key square channels.
// It predicts every pair from its own copy of the square and compares; depends on pdc_pkg.
`timescale 1ns / 1ps

module playfair_digraph_cipher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [4:0] letter, [7:5] zero
    input  logic [0:0]  i_s_tuser,   // [0] mode
    input  logic        i_s_tlast,   // message_end
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [4:0] first, [9:5] second, [10] first_keep,
                                     // [11] second_keep, [15:12] zero
    input  logic        i_m_tlast,   // run_end
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [24:0] i_cfg_data,
    output int          o_errors,
    output int          o_waiting,
    output int          o_pairs
);
    import pdc_pkg::*;

    typedef struct packed {
        t_letter first;
        t_letter second;
        logic    first_keep;
        logic    second_keep;
        logic    run_end;
    } t_cipher_pair;

    t_square      key_sq;
    t_letter      held_letter;
    logic         held_valid;
    t_cipher_pair pair_q[$];
    int           errors;
    int           pairs;

    initial begin
        errors    = 0;
        pairs     = 0;
        o_errors  = 0;
        o_waiting = 0;
        o_pairs   = 0;
    end

    function automatic t_letter cell_of(input int r, input int c);
        return key_sq[r][5*c +: 5];
    endfunction

    // The last matching cell in row-major order wins; no match means row 0, column 0.
    task automatic find_cell(input t_letter l, output int r, output int c);
        int i;
        int j;
        r = 0;
        c = 0;
        for (i = 0; i < 5; i++)
            for (j = 0; j < 5; j++)
                if (cell_of(i, j) == l) begin
                    r = i;
                    c = j;
                end
    endtask

    task automatic push_pair(input t_letter a, input t_letter b, input logic dec,
                             input logic last);
        int           r1;
        int           c1;
        int           r2;
        int           c2;
        int           step;
        t_cipher_pair p;
        step = dec ? 4 : 1;
        find_cell(a, r1, c1);
        find_cell(b, r2, c2);
        if (r1 == r2) begin
            p.first  = cell_of(r1, (c1 + step) % 5);
            p.second = cell_of(r2, (c2 + step) % 5);
        end else if (c1 == c2) begin
            p.first  = cell_of((r1 + step) % 5, c1);
            p.second = cell_of((r2 + step) % 5, c2);
        end else begin
            p.first  = cell_of(r1, c2);
            p.second = cell_of(r2, c1);
        end
        p.first_keep  = !(dec && p.first == LETTER_X);
        p.second_keep = !(dec && p.second == LETTER_X);
        p.run_end     = last;
        pair_q.push_back(p);
    endtask

    task automatic take_letter(input logic dec, input t_letter raw, input logic last);
        t_letter l;
        l = (raw == LETTER_J) ? LETTER_I : raw;
        if (!held_valid) begin
            if (last) begin
                push_pair(l, LETTER_X, dec, 1'b1);
            end else begin
                held_letter = l;
                held_valid  = 1'b1;
            end
        end else if (!dec && held_letter == l) begin
            push_pair(held_letter, LETTER_X, 1'b0, 1'b0);
            if (last) begin
                push_pair(l, LETTER_X, 1'b0, 1'b1);
                held_valid  = 1'b0;
                held_letter = '0;
            end
        end else begin
            push_pair(held_letter, l, dec, last);
            held_valid  = 1'b0;
            held_letter = '0;
        end
    endtask

    task automatic check_field(input string what, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic check_pair();
        t_cipher_pair e;
        if (pair_q.size() == 0) begin
            $display("%0t ns: unexpected pair, expected none, actual data %h last %b",
                     $time, i_m_tdata, i_m_tlast);
            errors++;
        end else begin
            e = pair_q.pop_front();
            check_field("first_letter", e.first, i_m_tdata[4:0]);
            check_field("second_letter", e.second, i_m_tdata[9:5]);
            check_field("first_keep", e.first_keep, i_m_tdata[10]);
            check_field("second_keep", e.second_keep, i_m_tdata[11]);
            check_field("run_end", e.run_end, i_m_tlast);
        end
        pairs++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_sq      = SQUARE_RESET;
            held_letter = '0;
            held_valid  = 1'b0;
            pair_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= CFG_ROW_LAST)
                key_sq[i_cfg_index] = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                take_letter(i_s_tuser[0], i_s_tdata[4:0], i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_pair();
        end
        o_waiting <= pair_q.size();
        o_errors  <= errors;
        o_pairs   <= pairs;
    end

endmodule

[tb/playfair_digraph_cipher_tb.sv]
// Top of the Playfair digraph cipher testbench: clock, reset, stimulus, pacing and verdict.
// Depends on pdc_pkg, the cipher block and playfair_digraph_cipher_checker.
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;
    import pdc_pkg::*;

    // Mode codes carried on tuser.
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // The index field has eight slots; only the first five hold square rows.
    localparam int REG_SLOTS = 8;

    // Extra settling time at the end of drain, after the last pair has come out.
    localparam int SETTLE_CYCLES = 8;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        o_s_tready;

    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;

    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [24:0] cfg_data = '0;

    int          errors;
    int          waiting;
    int          pairs;

    // Pacing knobs, in percent of cycles.
    int          send_idle = 0;
    int          recv_stall = 0;

    // The stimulus process bumps hold_req; the receiver process then holds off on its own.
    int          hold_req = 0;
    int          hold_seen;
    int          hold_left;

    int          letters_sent = 0;
    int          squares_loaded = 0;
    int          quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    playfair_digraph_cipher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    playfair_digraph_cipher_checker pair_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_waiting   (waiting),
        .o_pairs     (pairs)
    );

    // Receiver side. It stalls at random at the current rate, and when a hold-off is
    // requested it keeps tready low for a fixed stretch that it counts itself.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Watchdog. Any accepted item on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)
            || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item accepted for %0d cycles at %0t ns",
                     WATCHDOG_LIMIT, $time);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one letter and returns in the time step of the edge that accepts it. tvalid
    // stays high into the next item, so back-to-back items see no gap unless one is drawn.
    task automatic send_item(input logic mode, input t_letter letter, input logic msg_end);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, letter};
        s_tuser  <= mode;
        s_tlast  <= msg_end;
        do @(posedge i_clk); while (!o_s_tready);
        letters_sent++;
    endtask

    // Waits until every predicted pair has come out, then lets the block settle, so that
    // a register write can never race a pair still in flight. The first edge is always
    // taken, since the checker's count is registered and lags the last accept.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all five rows. With stray set it also writes the unused indexes, which the
    // block must ignore, so the prediction keeps the square just written.
    task automatic load_square(input t_square sq, input bit stray);
        int k;
        for (k = 0; k <= CFG_ROW_LAST; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(k);
            cfg_data  <= sq[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        if (stray) begin
            for (k = CFG_ROW_LAST + 1; k < REG_SLOTS; k++) begin
                cfg_valid <= 1'b1;
                cfg_index <= 3'(k);
                cfg_data  <= (k == REG_SLOTS - 1) ? '1 : 25'($urandom);
                do @(posedge i_clk); while (!o_cfg_ready);
            end
        end
        cfg_valid <= 1'b0;
        squares_loaded++;
    endtask

    // A proper key square: the 25 letters other than J in shuffled order.
    function automatic t_square shuffled_square();
        t_letter pool[25];
        t_letter tmp;
        t_square sq;
        int      n;
        int      k;
        int      j;
        n = 0;
        for (k = 0; k < 26; k++)
            if (t_letter'(k) != LETTER_J) begin
                pool[n] = t_letter'(k);
                n++;
            end
        for (k = 24; k > 0; k--) begin
            j       = $urandom_range(k);
            tmp     = pool[k];
            pool[k] = pool[j];
            pool[j] = tmp;
        end
        for (k = 0; k < 25; k++)
            sq[k / 5][5*(k % 5) +: 5] = pool[k];
        return sq;
    endfunction

    // Raw register contents: duplicate cells, missing letters and codes above Z.
    function automatic t_square raw_square();
        t_square sq;
        int      k;
        for (k = 0; k < 5; k++)
            sq[k] = 25'($urandom);
        return sq;
    endfunction

    // Mostly plain letters, with J, X, repeats (doubled letters) and out-of-range codes
    // mixed in so that every branch of the pairing logic keeps getting hit.
    function automatic t_letter pick_letter(input t_letter prev);
        int r;
        r = $urandom_range(99);
        if (r < 58)
            return t_letter'($urandom_range(25));
        else if (r < 67)
            return LETTER_J;
        else if (r < 76)
            return LETTER_X;
        else if (r < 93)
            return prev;
        else
            return t_letter'($urandom_range(31, 26));
    endfunction

    // Random messages of random length. Each message mostly keeps one mode, but now and then
    // a letter flips it. The final item always ends a message so that no letter is left
    // pending across a square change. hold_at > 0 requests the long hold-off at that item.
    task automatic send_messages(input int n_items, input int hold_at);
        int      sent;
        int      len;
        int      k;
        logic    mode;
        logic    m;
        logic    msg_end;
        t_letter prev;
        t_letter l;
        sent = 0;
        prev = '0;
        while (sent < n_items) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(8, 1);
            mode = 1'($urandom_range(1));
            for (k = 0; k < len && sent < n_items; k++) begin
                l       = pick_letter(prev);
                m       = ($urandom_range(9) == 0) ? ~mode : mode;
                msg_end = (k == len - 1) || (sent + 1 == n_items);
                send_item(m, l, msg_end);
                prev = l;
                sent++;
                if (sent == hold_at)
                    hold_req <= hold_req + 1;
            end
        end
    endtask

    task automatic set_pacing(input int idle_pct, input int stall_pct);
        send_idle  = idle_pct;
        recv_stall <= stall_pct;
    endtask

    initial begin
        // Hold reset, then release it at a rising edge.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the plain square after reset:
        // ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ.
        set_pacing(0, 0);
        send_item(MODE_ENC, 5'd0, 1'b0);      // A B: same row
        send_item(MODE_ENC, 5'd1, 1'b0);
        send_item(MODE_ENC, 5'd0, 1'b0);      // A F: same column
        send_item(MODE_ENC, 5'd5, 1'b0);
        send_item(MODE_ENC, 5'd0, 1'b0);      // A G: rectangle
        send_item(MODE_ENC, 5'd6, 1'b0);
        send_item(MODE_ENC, 5'd11, 1'b0);     // L L M: doubled letter gets an X
        send_item(MODE_ENC, 5'd11, 1'b0);
        send_item(MODE_ENC, 5'd12, 1'b0);
        send_item(MODE_ENC, 5'd4, 1'b0);      // E E at the end: two pairs from one item
        send_item(MODE_ENC, 5'd4, 1'b1);
        send_item(MODE_ENC, 5'd25, 1'b1);     // lone final Z, padded with X
        send_item(MODE_DEC, 5'd24, 1'b0);     // Y Z decrypt: the X that comes out is dropped
        send_item(MODE_DEC, 5'd25, 1'b0);
        send_item(MODE_DEC, LETTER_X, 1'b1);  // lone final letter in decrypt mode
        send_item(MODE_ENC, LETTER_J, 1'b0);  // J read as I, and the row wraps around
        send_item(MODE_ENC, 5'd10, 1'b0);
        send_item(MODE_DEC, 5'd0, 1'b0);      // doubled letter in decrypt: no X inserted
        send_item(MODE_DEC, 5'd0, 1'b0);
        send_item(MODE_ENC, 5'd1, 1'b0);      // mixed modes: the completing item decides
        send_item(MODE_DEC, 5'd2, 1'b0);
        send_item(MODE_ENC, 5'd31, 1'b0);     // code above Z is not in the square
        send_item(MODE_ENC, 5'd0, 1'b0);
        send_item(MODE_DEC, 5'd21, 1'b0);     // V Z decrypt wraps left, ends the message
        send_item(MODE_DEC, 5'd25, 1'b1);
        drain();

        // No idling, on a shuffled key square.
        load_square(shuffled_square(), 1'b0);
        set_pacing(0, 0);
        send_messages(250, 0);
        drain();

        // Sender mostly idle.
        load_square(shuffled_square(), 1'b1);
        set_pacing(78, 0);
        send_messages(200, 0);
        drain();

        // Receiver mostly stalled, with one long hold-off while the sender keeps offering
        // items back to back, so the queue fills and the input stalls.
        load_square(shuffled_square(), 1'b0);
        set_pacing(0, 78);
        send_messages(200, 40);
        drain();

        // Extremes of the square registers: every cell A, then every cell code 31.
        load_square('0, 1'b0);
        set_pacing(38, 38);
        send_messages(60, 0);
        drain();

        load_square('1, 1'b1);
        send_messages(60, 0);
        drain();

        // Raw register contents with duplicates and missing letters.
        load_square(raw_square(), 1'b0);
        send_messages(130, 0);
        drain();

        // Back to a proper square, both sides idling.
        load_square(shuffled_square(), 1'b1);
        send_messages(250, 0);
        drain();

        $display("Summary: %0d letters sent and %0d pairs checked over %0d key squares,",
                 letters_sent, pairs, squares_loaded);
        $display("with free-running, sender-idle, receiver-stall, hold-off and mixed pacing.");
        if (errors == 0 && waiting == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
